### hw/rtl/hts_pkg.sv
// Shared types and constants of the Huffman tree stream decoder.
package hts_pkg;

   localparam int SYMBOL_W = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 31;
   localparam int BIT_CNT_W = $clog2(SYMBOL_W);

   localparam logic [STATUS_W-1:0] STATUS_SYMBOL    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EARLY_END = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TREE_FULL = 2'd2;

   typedef enum logic [3:0] {
      PH_NODE = 4'b0001,
      PH_LEAF = 4'b0010,
      PH_WALK = 4'b0100,
      PH_STOP = 4'b1000
   } phase_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_BIT   = 6'b000010,
      ST_POP   = 6'b000100,
      ST_EVAL  = 6'b001000,
      ST_END   = 6'b010000,
      ST_FLUSH = 6'b100000
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic bit_step;
      logic pop_step;
      logic eval_step;
      logic end_step;
      logic flush_step;
   } cmd_type;

   typedef struct packed {
      logic needs_pop;
      logic needs_eval;
      logic emit_bit;
      logic emit_eval;
      logic emit_end;
      logic pend_valid;
      logic push_ok;
      logic flush_ok;
   } stat_type;

endpackage

### hw/rtl/hts_ifs.sv
// Item, result and register write channels of the Huffman tree stream decoder.
interface hts_req_if;
   logic                         valid;
   logic                         ready;
   logic [hts_pkg::SYMBOL_W-1:0] stream_byte;
   logic                         final_byte;

   modport source (output valid, output stream_byte, output final_byte, input ready);
   modport sink (input valid, input stream_byte, input final_byte, output ready);
endinterface

interface hts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hts_pkg::SYMBOL_W-1:0] symbol;
   logic [hts_pkg::STATUS_W-1:0] status;
   logic                         run_end;
   logic                         all_done;

   modport source (output valid, output symbol, output status, output run_end,
                   output all_done, input ready);
   modport sink (input valid, input symbol, input status, input run_end,
                 input all_done, output ready);
endinterface

interface hts_csr_if;
   logic                        valid;
   logic                        ready;
   logic [hts_pkg::COUNT_W-1:0] symbols_wanted;

   modport source (output valid, output symbols_wanted, input ready);
   modport sink (input valid, input symbols_wanted, output ready);
endinterface

### hw/rtl/hts_ctrl.sv
// Sequencer that steps one input byte through the datapath bit by bit.
module hts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hts_pkg::stat_type stat,
   output hts_pkg::cmd_type  cmd
);
   import hts_pkg::*;

   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(SYMBOL_W - 1);

   ctrl_state_type       state_ff, state_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   ctrl_state_type       next_after_bit;
   logic [BIT_CNT_W-1:0] cnt_after_bit;

   // advance to the next bit, or close the item after the last one
   always_comb begin
      if (bit_cnt_ff == '0) begin
         next_after_bit = ST_END;
         cnt_after_bit  = bit_cnt_ff;
      end else begin
         next_after_bit = ST_BIT;
         cnt_after_bit  = bit_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = BIT_LAST;
               state_in   = ST_BIT;
            end
         end
         ST_BIT: begin
            if (!stat.emit_bit || stat.push_ok) begin
               cmd.bit_step = 1'b1;
               if (stat.needs_pop) begin
                  state_in = ST_POP;
               end else if (stat.needs_eval) begin
                  state_in = ST_EVAL;
               end else begin
                  state_in   = next_after_bit;
                  bit_cnt_in = cnt_after_bit;
               end
            end
         end
         ST_POP: begin
            cmd.pop_step = 1'b1;
            state_in     = next_after_bit;
            bit_cnt_in   = cnt_after_bit;
         end
         ST_EVAL: begin
            if (!stat.emit_eval || stat.push_ok) begin
               cmd.eval_step = 1'b1;
               state_in      = next_after_bit;
               bit_cnt_in    = cnt_after_bit;
            end
         end
         ST_END: begin
            if (!stat.emit_end || stat.push_ok) begin
               cmd.end_step = 1'b1;
               state_in     = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid || stat.flush_ok) begin
               cmd.flush_step = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !stat.pend_valid)
      else $error("held result left behind at end of item");

   a_eval_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && stat.emit_eval && !stat.push_ok |=> state_ff == ST_EVAL)
      else $error("walk result dropped while output stalled");

   a_flush_before_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH && stat.pend_valid && !stat.flush_ok |=> state_ff == ST_FLUSH)
      else $error("final result of item dropped");

endmodule

### hw/rtl/hts_datapath.sv
// Tree table, parent stack, stream state and result registers of the decoder.
module hts_datapath #(
   parameter int MAX_NODES   = 512,
   parameter int STACK_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hts_pkg::cmd_type             cmd,
   output hts_pkg::stat_type            stat,
   input  logic [hts_pkg::SYMBOL_W-1:0] req_stream_byte,
   input  logic                         req_final_byte,
   input  logic                         csr_valid,
   input  logic [hts_pkg::COUNT_W-1:0]  csr_symbols_wanted,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hts_pkg::SYMBOL_W-1:0] rsp_symbol,
   output logic [hts_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_run_end,
   output logic                         rsp_all_done
);
   import hts_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int EW = NW + SYMBOL_W + 1;
   localparam int LEAF_BIT = EW - 1;
   localparam logic [NW:0] NODES_LIMIT = (NW + 1)'(MAX_NODES);
   localparam logic [SW:0] STACK_LIMIT = (SW + 1)'(STACK_DEPTH);

   logic [EW-1:0] node_mem [MAX_NODES];
   logic [NW-1:0] stack_mem [STACK_DEPTH];

   logic          tbl_we, tbl_re;
   logic [NW-1:0] tbl_waddr, tbl_raddr;
   logic [EW-1:0] tbl_wdata, tbl_rdata_ff;
   logic          stk_we, stk_re;
   logic [SW-1:0] stk_waddr, stk_raddr;
   logic [NW-1:0] stk_wdata, stk_rdata_ff;

   phase_type             phase_ff, phase_in;
   logic [NW:0]           nodes_built_ff, nodes_built_in;
   logic [SW:0]           stack_top_ff, stack_top_in;
   logic [SYMBOL_W-1:0]   leaf_bits_ff, leaf_bits_in;
   logic [BIT_CNT_W-1:0]  leaf_cnt_ff, leaf_cnt_in;
   logic [NW-1:0]         walk_node_ff, walk_node_in;
   logic [EW-1:0]         cur_entry_ff, cur_entry_in;
   logic [EW-1:0]         root_entry_ff, root_entry_in;
   logic [COUNT_W-1:0]    emitted_ff, emitted_in;
   logic [COUNT_W-1:0]    wanted_ff, wanted_in;
   logic [SYMBOL_W-1:0]   byte_ff, byte_in;
   logic                  final_ff, final_in;

   logic                  pend_valid_ff, pend_valid_in;
   logic [SYMBOL_W-1:0]   pend_symbol_ff, pend_symbol_in;
   logic [STATUS_W-1:0]   pend_status_ff, pend_status_in;
   logic                  pend_done_ff, pend_done_in;
   logic                  out_valid_ff, out_valid_in;
   logic [SYMBOL_W-1:0]   out_symbol_ff, out_symbol_in;
   logic [STATUS_W-1:0]   out_status_ff, out_status_in;
   logic                  out_run_end_ff, out_run_end_in;
   logic                  out_done_ff, out_done_in;

   logic                  cur_bit;
   logic [EW-1:0]         walk_entry;
   logic [NW-1:0]         child;
   logic                  reached;
   logic [COUNT_W-1:0]    emitted_inc;
   logic                  done_next;
   logic                  node_full, stack_full;
   logic [NW:0]           nodes_dec;
   logic [SW:0]           stack_dec;
   logic [SYMBOL_W-1:0]   leaf_shift;
   logic                  push;
   logic [SYMBOL_W-1:0]   push_symbol;
   logic [STATUS_W-1:0]   push_status;
   logic                  push_done;
   logic                  clear;

   assign cur_bit     = byte_ff[SYMBOL_W-1];
   assign walk_entry  = (walk_node_ff == '0) ? root_entry_ff : cur_entry_ff;
   assign child       = cur_bit ? walk_entry[NW+SYMBOL_W-1:SYMBOL_W] : walk_node_ff + 1'b1;
   assign reached     = emitted_ff >= wanted_ff;
   assign emitted_inc = emitted_ff + 1'b1;
   assign done_next   = emitted_inc >= wanted_ff;
   assign node_full   = nodes_built_ff >= NODES_LIMIT;
   assign stack_full  = stack_top_ff >= STACK_LIMIT;
   assign nodes_dec   = nodes_built_ff - 1'b1;
   assign stack_dec   = stack_top_ff - 1'b1;
   assign leaf_shift  = {leaf_bits_ff[SYMBOL_W-2:0], cur_bit};

   always_comb begin
      stat.needs_pop  = phase_ff == PH_LEAF && leaf_cnt_ff == BIT_CNT_W'(SYMBOL_W - 1)
                        && stack_top_ff != '0;
      stat.needs_eval = phase_ff == PH_WALK && !reached && !walk_entry[LEAF_BIT];
      stat.emit_bit   = (phase_ff == PH_NODE && (node_full || (!cur_bit && stack_full)))
                        || (phase_ff == PH_WALK && !reached && walk_entry[LEAF_BIT]);
      stat.emit_eval  = tbl_rdata_ff[LEAF_BIT];
      stat.emit_end   = final_ff && phase_ff != PH_STOP;
      stat.pend_valid = pend_valid_ff;
      stat.push_ok    = !pend_valid_ff || !out_valid_ff || rsp_ready;
      stat.flush_ok   = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      phase_in       = phase_ff;
      nodes_built_in = nodes_built_ff;
      stack_top_in   = stack_top_ff;
      leaf_bits_in   = leaf_bits_ff;
      leaf_cnt_in    = leaf_cnt_ff;
      walk_node_in   = walk_node_ff;
      cur_entry_in   = cur_entry_ff;
      root_entry_in  = root_entry_ff;
      emitted_in     = emitted_ff;
      wanted_in      = wanted_ff;
      byte_in        = byte_ff;
      final_in       = final_ff;
      pend_valid_in  = pend_valid_ff;
      pend_symbol_in = pend_symbol_ff;
      pend_status_in = pend_status_ff;
      pend_done_in   = pend_done_ff;
      out_valid_in   = out_valid_ff;
      out_symbol_in  = out_symbol_ff;
      out_status_in  = out_status_ff;
      out_run_end_in = out_run_end_ff;
      out_done_in    = out_done_ff;
      tbl_we         = 1'b0;
      tbl_waddr      = nodes_built_ff[NW-1:0];
      tbl_wdata      = '0;
      tbl_re         = 1'b0;
      tbl_raddr      = child;
      stk_we         = 1'b0;
      stk_waddr      = stack_top_ff[SW-1:0];
      stk_wdata      = nodes_built_ff[NW-1:0];
      stk_re         = 1'b0;
      stk_raddr      = stack_dec[SW-1:0];
      push           = 1'b0;
      push_symbol    = '0;
      push_status    = STATUS_SYMBOL;
      push_done      = 1'b0;
      clear          = 1'b0;

      if (csr_valid) begin
         wanted_in = csr_symbols_wanted;
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load) begin
         byte_in  = req_stream_byte;
         final_in = req_final_byte;
      end

      if (cmd.bit_step) begin
         byte_in = {byte_ff[SYMBOL_W-2:0], 1'b0};
         case (phase_ff)
            PH_NODE: begin
               if (node_full || (!cur_bit && stack_full)) begin
                  push        = 1'b1;
                  push_status = STATUS_TREE_FULL;
                  phase_in    = PH_STOP;
               end else if (cur_bit) begin
                  nodes_built_in = nodes_built_ff + 1'b1;
                  leaf_bits_in   = '0;
                  leaf_cnt_in    = '0;
                  phase_in       = PH_LEAF;
               end else begin
                  nodes_built_in = nodes_built_ff + 1'b1;
                  stk_we         = 1'b1;
                  stack_top_in   = stack_top_ff + 1'b1;
                  tbl_we         = 1'b1;
               end
            end
            PH_LEAF: begin
               leaf_bits_in = leaf_shift;
               if (leaf_cnt_ff == BIT_CNT_W'(SYMBOL_W - 1)) begin
                  leaf_cnt_in = '0;
                  tbl_we      = 1'b1;
                  tbl_waddr   = nodes_dec[NW-1:0];
                  tbl_wdata   = {1'b1, {NW{1'b0}}, leaf_shift};
                  if (stack_top_ff != '0) begin
                     stk_re       = 1'b1;
                     stack_top_in = stack_dec;
                     phase_in     = PH_NODE;
                  end else begin
                     walk_node_in = '0;
                     phase_in     = reached ? PH_STOP : PH_WALK;
                  end
               end else begin
                  leaf_cnt_in = leaf_cnt_ff + 1'b1;
               end
            end
            PH_WALK: begin
               if (reached) begin
                  phase_in = PH_STOP;
               end else if (walk_entry[LEAF_BIT]) begin
                  push         = 1'b1;
                  push_symbol  = walk_entry[SYMBOL_W-1:0];
                  push_done    = done_next;
                  emitted_in   = emitted_inc;
                  walk_node_in = '0;
                  if (done_next) begin
                     phase_in = PH_STOP;
                  end
               end else begin
                  walk_node_in = child;
                  tbl_re       = 1'b1;
               end
            end
            PH_STOP: begin
               phase_in = PH_STOP;
            end
            default: begin
               phase_in = PH_STOP;
            end
         endcase
      end

      if (cmd.pop_step) begin
         tbl_we    = 1'b1;
         tbl_waddr = stk_rdata_ff;
         tbl_wdata = {1'b0, nodes_built_ff[NW-1:0], {SYMBOL_W{1'b0}}};
      end

      if (cmd.eval_step) begin
         if (tbl_rdata_ff[LEAF_BIT]) begin
            push         = 1'b1;
            push_symbol  = tbl_rdata_ff[SYMBOL_W-1:0];
            push_done    = done_next;
            emitted_in   = emitted_inc;
            walk_node_in = '0;
            if (done_next) begin
               phase_in = PH_STOP;
            end
         end else begin
            cur_entry_in = tbl_rdata_ff;
         end
      end

      if (cmd.end_step) begin
         if (final_ff && phase_ff != PH_STOP) begin
            push        = 1'b1;
            push_status = STATUS_EARLY_END;
         end
         clear = final_ff;
      end

      if (push) begin
         if (pend_valid_ff) begin
            out_valid_in   = 1'b1;
            out_symbol_in  = pend_symbol_ff;
            out_status_in  = pend_status_ff;
            out_run_end_in = 1'b0;
            out_done_in    = pend_done_ff;
         end
         pend_valid_in  = 1'b1;
         pend_symbol_in = push_symbol;
         pend_status_in = push_status;
         pend_done_in   = push_done;
      end

      if (cmd.flush_step && pend_valid_ff) begin
         out_valid_in   = 1'b1;
         out_symbol_in  = pend_symbol_ff;
         out_status_in  = pend_status_ff;
         out_run_end_in = 1'b1;
         out_done_in    = pend_done_ff;
         pend_valid_in  = 1'b0;
      end

      if (clear) begin
         stack_top_in   = '0;
         nodes_built_in = '0;
         phase_in       = PH_NODE;
         leaf_bits_in   = '0;
         leaf_cnt_in    = '0;
         walk_node_in   = '0;
         emitted_in     = '0;
      end

      if (tbl_we && tbl_waddr == '0) begin
         root_entry_in = tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         node_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rdata_ff <= node_mem[tbl_raddr];
      end
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stack_mem[stk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_NODE;
         nodes_built_ff <= '0;
         stack_top_ff   <= '0;
         leaf_bits_ff   <= '0;
         leaf_cnt_ff    <= '0;
         walk_node_ff   <= '0;
         emitted_ff     <= '0;
         wanted_ff      <= '0;
         final_ff       <= 1'b0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         nodes_built_ff <= nodes_built_in;
         stack_top_ff   <= stack_top_in;
         leaf_bits_ff   <= leaf_bits_in;
         leaf_cnt_ff    <= leaf_cnt_in;
         walk_node_ff   <= walk_node_in;
         emitted_ff     <= emitted_in;
         wanted_ff      <= wanted_in;
         final_ff       <= final_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_entry_ff   <= cur_entry_in;
      root_entry_ff  <= root_entry_in;
      byte_ff        <= byte_in;
      pend_symbol_ff <= pend_symbol_in;
      pend_status_ff <= pend_status_in;
      pend_done_ff   <= pend_done_in;
      out_symbol_ff  <= out_symbol_in;
      out_status_ff  <= out_status_in;
      out_run_end_ff <= out_run_end_in;
      out_done_ff    <= out_done_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_symbol   = out_symbol_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_run_end  = out_run_end_ff;
   assign rsp_all_done = out_done_ff;

   a_flag_carries_no_symbol: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != STATUS_SYMBOL |-> out_symbol_ff == '0 && !out_done_ff)
      else $error("flag result carries symbol or completion");

   a_flush_marks_run_end: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_step && pend_valid_ff |=> out_valid_ff && out_run_end_ff)
      else $error("last result of item not marked");

   a_full_table_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.bit_step && phase_ff == PH_NODE && node_full && !final_ff |=> phase_ff == PH_STOP)
      else $error("node beyond table capacity accepted");

endmodule

### hw/rtl/huffman_tree_stream_decoder.sv
// Top level of the Huffman tree stream decoder.
// Each accepted byte is taken apart one bit per cycle, most significant first, unless a
// stalled result port or an extra step holds the sequencer: the byte is accepted, its eight
// bits are stepped, the item is closed and its last result is handed over. A leaf that
// completes a pending inner node adds a pop step for the parent write, and a walk bit taken
// at an inner node adds an evaluate step for the registered read of the node table; both
// extras come from the single write port and the registered read port of the node table.
// A stalled result port holds the sequencer whenever a new result has nowhere to go. The
// node table and parent stack are never cleared: there is no start-up sweep and the block
// accepts bytes from the first cycle after reset. The symbol count register may be written
// at any time the block is idle and keeps its value across streams.
module huffman_tree_stream_decoder #(
   parameter int MAX_NODES   = 512,
   parameter int STACK_DEPTH = 256
) (
   input logic       clock,
   input logic       reset,
   hts_req_if.sink   req_if,
   hts_rsp_if.source rsp_if,
   hts_csr_if.sink   csr_if
);
   import hts_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_if.ready = 1'b1;

   hts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hts_datapath #(
      .MAX_NODES   (MAX_NODES),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_stream_byte    (req_if.stream_byte),
      .req_final_byte     (req_if.final_byte),
      .csr_valid          (csr_if.valid),
      .csr_symbols_wanted (csr_if.symbols_wanted),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_symbol         (rsp_if.symbol),
      .rsp_status         (rsp_if.status),
      .rsp_run_end        (rsp_if.run_end),
      .rsp_all_done       (rsp_if.all_done)
   );

endmodule
